// File: rtl/jac_pkg.sv
// ============================================================================
// jac_pkg
// Shared widths, register map and constants of the joystick axis conditioner.
// ============================================================================
`default_nettype none

package jac_pkg;

    // field widths
    localparam int RAW_W    = 17;
    localparam int SLOT_W   = 2;
    localparam int SRC_W    = 3;
    localparam int DZ_W     = 15;
    localparam int MASK_W   = 4;
    localparam int OUT_W    = 18;
    localparam int NUM_AXES = 8;

    // half of the raw span, and the log2 of the full span, for the throttle mapping
    localparam int HALF_SPAN = 32768;
    localparam int SPAN_LOG2 = 16;

    // logical slot codes
    localparam logic [SLOT_W-1:0] SLOT_YAW      = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_PITCH    = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_ROLL     = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_THROTTLE = 2'd3;

    // register indexes (byte address is four times the index)
    localparam logic [2:0] REG_DEAD_ZONE       = 3'd0;
    localparam logic [2:0] REG_YAW_SOURCE      = 3'd1;
    localparam logic [2:0] REG_PITCH_SOURCE    = 3'd2;
    localparam logic [2:0] REG_ROLL_SOURCE     = 3'd3;
    localparam logic [2:0] REG_THROTTLE_SOURCE = 3'd4;
    localparam logic [2:0] REG_INVERT_MASK     = 3'd5;

    // register reset values
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST       = 15'd100;
    localparam logic [SRC_W-1:0]  YAW_SOURCE_RST      = 3'd0;
    localparam logic [SRC_W-1:0]  PITCH_SOURCE_RST    = 3'd1;
    localparam logic [SRC_W-1:0]  ROLL_SOURCE_RST     = 3'd5;
    localparam logic [SRC_W-1:0]  THROTTLE_SOURCE_RST = 3'd6;
    localparam logic [MASK_W-1:0] INVERT_MASK_RST     = 4'd0;

endpackage

`default_nettype wire

// File: rtl/joystick_axis_conditioner_core.sv
// ============================================================================
// joystick_axis_conditioner_core
// Dead zone, quadratic response and throttle mapping of one selected axis.
// ============================================================================
//
//  channel   dir   handshake          content
//  -------   ---   ---------          -------
//  s_*       in    tvalid / tready    eight raw axes, logical slot in tuser
//  m_*       out   tvalid / tready    conditioned axis value, Q format
//  apb       in    psel / penable     register writes and reads, pready high
//
//  One item a cycle sustained while the output is not stalled; the division
//  pipeline retires one quotient bit per stage.
//  Reset clears all valid bits and loads the register defaults.
//  Each stage holds its item while the next one is full and stalled, so
//  bubbles close up and a stall on the output loses and repeats nothing.
//
`default_nettype none

module joystick_axis_conditioner_core #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // raw snapshot; tdata from bit 0 up: raw_x, raw_y, raw_z, raw_rx,
    // raw_ry, raw_rz, raw_slider0, raw_slider1 (17 bits each)
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,
    // tuser: axis_slot (2 bits)
    input  wire logic [1:0]   s_tuser,

    // tdata from bit 0 up: axis_value (18 bits signed), zero padding
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,

    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int FB = FRACTION_BITS;
    localparam int RW = jac_pkg::RAW_W;
    localparam int OW = jac_pkg::OUT_W;
    localparam int VW = (FB + 2 > OW) ? FB + 2 : OW;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [jac_pkg::DZ_W-1:0]   dead_zone_reg;
    logic [jac_pkg::SRC_W-1:0]  yaw_source_reg;
    logic [jac_pkg::SRC_W-1:0]  pitch_source_reg;
    logic [jac_pkg::SRC_W-1:0]  roll_source_reg;
    logic [jac_pkg::SRC_W-1:0]  throttle_source_reg;
    logic [jac_pkg::MASK_W-1:0] invert_mask_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg       <= jac_pkg::DEAD_ZONE_RST;
            yaw_source_reg      <= jac_pkg::YAW_SOURCE_RST;
            pitch_source_reg    <= jac_pkg::PITCH_SOURCE_RST;
            roll_source_reg     <= jac_pkg::ROLL_SOURCE_RST;
            throttle_source_reg <= jac_pkg::THROTTLE_SOURCE_RST;
            invert_mask_reg     <= jac_pkg::INVERT_MASK_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                jac_pkg::REG_DEAD_ZONE:       dead_zone_reg       <= pwdata[14:0];
                jac_pkg::REG_YAW_SOURCE:      yaw_source_reg      <= pwdata[2:0];
                jac_pkg::REG_PITCH_SOURCE:    pitch_source_reg    <= pwdata[2:0];
                jac_pkg::REG_ROLL_SOURCE:     roll_source_reg     <= pwdata[2:0];
                jac_pkg::REG_THROTTLE_SOURCE: throttle_source_reg <= pwdata[2:0];
                jac_pkg::REG_INVERT_MASK:     invert_mask_reg     <= pwdata[3:0];
                default:                      ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[4:2])
            jac_pkg::REG_DEAD_ZONE:       prdata = {17'd0, dead_zone_reg};
            jac_pkg::REG_YAW_SOURCE:      prdata = {29'd0, yaw_source_reg};
            jac_pkg::REG_PITCH_SOURCE:    prdata = {29'd0, pitch_source_reg};
            jac_pkg::REG_ROLL_SOURCE:     prdata = {29'd0, roll_source_reg};
            jac_pkg::REG_THROTTLE_SOURCE: prdata = {29'd0, throttle_source_reg};
            jac_pkg::REG_INVERT_MASK:     prdata = {28'd0, invert_mask_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // squared divisor, (32768 - dead zone)^2, follows the dead zone register
    logic [15:0] span_w;
    logic [30:0] div_sq_reg;
    logic [30:0] div_sq_next;
    logic [31:0] div_prod_w;

    assign span_w      = 16'(17'(jac_pkg::HALF_SPAN) - {2'b00, dead_zone_reg});
    assign div_prod_w  = span_w * span_w;
    assign div_sq_next = div_prod_w[30:0];

    always_ff @(posedge clk)
    begin
        div_sq_reg <= div_sq_next;
    end

    // ------------------------------------------------------------------
    // ready chain: a stage takes a new item when empty or moving on
    // ------------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_out;
    logic dready [0:FB+1];
    logic in_xfer;

    assign rdy_out       = !out_valid_reg || m_tready;
    assign dready[FB+1]  = rdy_out;
    assign rdy3          = !v3_reg || dready[0];
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_tready      = rdy1;
    assign in_xfer       = s_tvalid && rdy1;

    // ------------------------------------------------------------------
    // stage 1: source select and saturation
    // ------------------------------------------------------------------
    logic [jac_pkg::SRC_W-1:0] src_w;
    logic signed [RW-1:0]      raw_w;
    logic signed [RW-1:0]      sat_next;
    logic signed [RW-1:0]      sat_reg;
    logic                      thr1_reg;
    logic                      inv1_reg;

    always_comb
    begin
        unique case (s_tuser)
            jac_pkg::SLOT_YAW:      src_w = yaw_source_reg;
            jac_pkg::SLOT_PITCH:    src_w = pitch_source_reg;
            jac_pkg::SLOT_ROLL:     src_w = roll_source_reg;
            jac_pkg::SLOT_THROTTLE: src_w = throttle_source_reg;
            default:                src_w = yaw_source_reg;
        endcase
        raw_w = s_tdata[src_w * RW +: RW];
        if (raw_w < -17'sd32768)
            sat_next = -17'sd32768;
        else if (raw_w > 17'sd32768)
            sat_next = 17'sd32768;
        else
            sat_next = raw_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sat_reg  <= sat_next;
            thr1_reg <= (s_tuser == jac_pkg::SLOT_THROTTLE);
            inv1_reg <= invert_mask_reg[s_tuser];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitude, dead zone removal, throttle offset
    // ------------------------------------------------------------------
    logic        neg_w;
    logic [15:0] mag_w;
    logic [15:0] m_next;
    logic [16:0] u_next;
    logic [17:0] u_sum_w;
    logic [15:0] m2_reg;
    logic [16:0] u2_reg;
    logic        thr2_reg;
    logic        flip2_reg;

    always_comb
    begin
        neg_w = sat_reg[RW-1];
        mag_w = neg_w ? 16'(-sat_reg) : 16'(sat_reg);
        if (mag_w > {1'b0, dead_zone_reg})
            m_next = mag_w - {1'b0, dead_zone_reg};
        else
            m_next = 16'd0;
        if (inv1_reg)
            u_sum_w = 18'(jac_pkg::HALF_SPAN) - 18'(sat_reg);
        else
            u_sum_w = 18'(sat_reg) + 18'(jac_pkg::HALF_SPAN);
        u_next = u_sum_w[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            m2_reg    <= m_next;
            u2_reg    <= u_next;
            thr2_reg  <= thr1_reg;
            flip2_reg <= neg_w ^ inv1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: square of the remaining magnitude
    // ------------------------------------------------------------------
    logic [31:0] sq_prod_w;
    logic [30:0] sq3_reg;
    logic [16:0] u3_reg;
    logic        thr3_reg;
    logic        flip3_reg;

    assign sq_prod_w = m2_reg * m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (rdy3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            sq3_reg   <= sq_prod_w[30:0];
            u3_reg    <= u2_reg;
            thr3_reg  <= thr2_reg;
            flip3_reg <= flip2_reg;
        end
    end

    // ------------------------------------------------------------------
    // division pipeline: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    logic        dv_reg   [0:FB];
    logic [30:0] rem_reg  [0:FB];
    logic [FB:0] q_reg    [0:FB];
    logic [16:0] du_reg   [0:FB];
    logic        dthr_reg [0:FB];
    logic        dflip_reg[0:FB];

    genvar k;
    generate
        for (k = 0; k <= FB; k++)
        begin : g_div
            logic        src_valid;
            logic [31:0] src_t;
            logic [FB:0] src_q;
            logic [16:0] src_u;
            logic        src_thr;
            logic        src_flip;
            logic        bit_w;
            logic [30:0] rem_next;
            logic [FB:0] q_next;

            if (k == 0)
            begin : g_head
                // first bit: the square against the squared divisor
                assign src_valid = v3_reg;
                assign src_t     = {1'b0, sq3_reg};
                assign src_q     = '0;
                assign src_u     = u3_reg;
                assign src_thr   = thr3_reg;
                assign src_flip  = flip3_reg;
            end
            else
            begin : g_body
                // later bits: doubled remainder
                assign src_valid = dv_reg[k-1];
                assign src_t     = {rem_reg[k-1], 1'b0};
                assign src_q     = q_reg[k-1];
                assign src_u     = du_reg[k-1];
                assign src_thr   = dthr_reg[k-1];
                assign src_flip  = dflip_reg[k-1];
            end

            assign bit_w    = src_t >= {1'b0, div_sq_reg};
            assign rem_next = bit_w ? 31'(src_t - {1'b0, div_sq_reg}) : src_t[30:0];
            assign q_next   = {src_q[FB-1:0], bit_w};

            assign dready[k] = !dv_reg[k] || dready[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[k] <= 1'b0;
                else if (dready[k])
                    dv_reg[k] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (dready[k] && src_valid)
                begin
                    rem_reg[k]   <= rem_next;
                    q_reg[k]     <= q_next;
                    du_reg[k]    <= src_u;
                    dthr_reg[k]  <= src_thr;
                    dflip_reg[k] <= src_flip;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // output stage: sign, throttle scaling, output register
    // ------------------------------------------------------------------
    logic [RW+FB-1:0]     thr_full_w;
    logic [RW+FB-1:0]     thr_scaled_w;
    logic signed [VW-1:0] mag_ext_w;
    logic signed [VW-1:0] value_w;
    logic [OW-1:0]        value_next;
    logic [OW-1:0]        value_reg;

    always_comb
    begin
        thr_full_w   = {du_reg[FB], {FB{1'b0}}};
        thr_scaled_w = thr_full_w >> jac_pkg::SPAN_LOG2;
        if (dthr_reg[FB])
        begin
            mag_ext_w = {{(VW-FB-1){1'b0}}, thr_scaled_w[FB:0]};
            value_w   = mag_ext_w;
        end
        else
        begin
            mag_ext_w = {{(VW-FB-1){1'b0}}, q_reg[FB]};
            value_w   = dflip_reg[FB] ? -mag_ext_w : mag_ext_w;
        end
        value_next = value_w[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy_out)
            out_valid_reg <= dv_reg[FB];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && dv_reg[FB])
            value_reg <= value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, value_reg};

endmodule

`default_nettype wire
